[design/flash_record_log_wear_level_core_defines.svh]
// Assertion macros shared by the flash record log RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef FLASH_RECORD_LOG_WEAR_LEVEL_CORE_DEFINES_SVH
`define FLASH_RECORD_LOG_WEAR_LEVEL_CORE_DEFINES_SVH

// Same-cycle implication, masked while in reset.
`define FRLWL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while in reset.
`define FRLWL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/frlwl_pkg.sv]
// Types, constants and codes for the flash record log core.
// No dependencies; compiled before every other file.
package frlwl_pkg;

  localparam int unsigned RECORD_SLOTS_DEF = 256;
  localparam int unsigned RECORD_WORDS_DEF = 4;
  localparam int unsigned MAX_WORDS        = 4;
  localparam int unsigned WORD_W           = 32;
  localparam int unsigned STATUS_W         = 3;
  localparam int unsigned SLOT_W           = 8;

  localparam logic [WORD_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;

  typedef enum logic [STATUS_W-1:0] {
    ST_READ      = 3'd0,
    ST_UNCHANGED = 3'd1,
    ST_OVERWRITE = 3'd2,
    ST_APPEND    = 3'd3,
    ST_ERASE     = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_DEC
  } fsm_t;

  typedef enum logic {
    WR_PLAIN,
    WR_MERGE
  } wr_mode_t;

  typedef enum logic [1:0] {
    OUT_PREV,
    OUT_NEW,
    OUT_MERGE,
    OUT_ERASED
  } out_sel_t;

  // Control from the sequencer to every lane
  typedef struct packed {
    logic     cap_en;
    logic     rd_en;
    logic     wr_en;
    wr_mode_t wr_mode;
    out_sel_t out_sel;
    logic     prev_ok;
    logic     cur_ok;
  } lane_ctl_t;

  // Per-word findings of one lane
  typedef struct packed {
    logic eq;
    logic sub;
    logic erased;
  } lane_flag_t;

endpackage

[design/frlwl_in_if.sv]
// Request channel of the flash record log core: valid/ready plus one item.
// Depends on frlwl_pkg for the word width.
interface frlwl_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [frlwl_pkg::WORD_W-1:0] new_word0;
  logic [frlwl_pkg::WORD_W-1:0] new_word1;
  logic [frlwl_pkg::WORD_W-1:0] new_word2;
  logic [frlwl_pkg::WORD_W-1:0] new_word3;

  modport source (output valid, cmd, new_word0, new_word1, new_word2, new_word3,
                  input ready);
  modport sink   (input valid, cmd, new_word0, new_word1, new_word2, new_word3,
                  output ready);
endinterface

[design/frlwl_out_if.sv]
// Result channel of the flash record log core: valid/ready plus one item.
// Depends on frlwl_pkg for field widths.
interface frlwl_out_if;
  logic                           valid;
  logic                           ready;
  logic [frlwl_pkg::WORD_W-1:0]   cur_word0;
  logic [frlwl_pkg::WORD_W-1:0]   cur_word1;
  logic [frlwl_pkg::WORD_W-1:0]   cur_word2;
  logic [frlwl_pkg::WORD_W-1:0]   cur_word3;
  logic [frlwl_pkg::STATUS_W-1:0] status;
  logic [frlwl_pkg::SLOT_W-1:0]   slot_used;

  modport source (output valid, cur_word0, cur_word1, cur_word2, cur_word3, status,
                  slot_used, input ready);
  modport sink   (input valid, cur_word0, cur_word1, cur_word2, cur_word3, status,
                  slot_used, output ready);
endinterface

[design/frlwl_lane.sv]
// One word lane: its bank of the page store, compare and program logic.
// Depends on frlwl_pkg.
module frlwl_lane #(
  parameter int unsigned RECORD_SLOTS = frlwl_pkg::RECORD_SLOTS_DEF,
  localparam int unsigned SIDX_W      = $clog2(RECORD_SLOTS)
) (
  input  logic                         clk,
  input  frlwl_pkg::lane_ctl_t         ctl_i,
  input  logic [SIDX_W-1:0]            addr_prev_i,
  input  logic [SIDX_W-1:0]            addr_cur_i,
  input  logic [SIDX_W-1:0]            wr_addr_i,
  input  logic [frlwl_pkg::WORD_W-1:0] nw_i,
  output frlwl_pkg::lane_flag_t        flag_o,
  output logic [frlwl_pkg::WORD_W-1:0] word_o
);
  import frlwl_pkg::*;

  logic [WORD_W-1:0] bank_mem [RECORD_SLOTS];
  logic [WORD_W-1:0] nw_r;
  logic [WORD_W-1:0] prev_q_r;
  logic [WORD_W-1:0] cur_q_r;
  logic [WORD_W-1:0] prev_eff;
  logic [WORD_W-1:0] cur_eff;
  logic [WORD_W-1:0] merged;
  logic [WORD_W-1:0] wdata;

  // Hold the new word for the whole item
  always_ff @(posedge clk) begin
    if (ctl_i.cap_en) begin
      nw_r <= nw_i;
    end
  end

  // Bank: two registered reads, one write
  always_ff @(posedge clk) begin
    if (ctl_i.rd_en) begin
      prev_q_r <= bank_mem[addr_prev_i];
      cur_q_r  <= bank_mem[addr_cur_i];
    end
    if (ctl_i.wr_en) begin
      bank_mem[wr_addr_i] <= wdata;
    end
  end

  // Slots not programmed since the last erase read as erased
  assign prev_eff = ctl_i.prev_ok ? prev_q_r : ERASED_WORD;
  assign cur_eff  = ctl_i.cur_ok  ? cur_q_r  : ERASED_WORD;
  assign merged   = cur_eff & nw_r;
  assign wdata    = (ctl_i.wr_mode == WR_MERGE) ? merged : nw_r;

  assign flag_o.eq     = (prev_eff == nw_r);
  assign flag_o.sub    = ((~prev_eff & nw_r) == '0);
  assign flag_o.erased = (nw_r == ERASED_WORD);

  always_comb begin
    unique case (ctl_i.out_sel)
      OUT_PREV:   word_o = prev_eff;
      OUT_NEW:    word_o = nw_r;
      OUT_MERGE:  word_o = merged;
      OUT_ERASED: word_o = ERASED_WORD;
      default:    word_o = ERASED_WORD;
    endcase
  end

endmodule

[design/frlwl_ctrl.sv]
// Sequencer and merge stage: fill pointer, decision over lane flags, result register.
// Depends on frlwl_pkg and flash_record_log_wear_level_core_defines.svh.
`include "flash_record_log_wear_level_core_defines.svh"

module frlwl_ctrl #(
  parameter int unsigned RECORD_SLOTS = frlwl_pkg::RECORD_SLOTS_DEF,
  parameter int unsigned RECORD_WORDS = frlwl_pkg::RECORD_WORDS_DEF,
  localparam int unsigned SIDX_W      = $clog2(RECORD_SLOTS),
  localparam int unsigned FW          = $clog2(RECORD_SLOTS + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  frlwl_pkg::lane_flag_t          flag_i [RECORD_WORDS],
  input  logic [frlwl_pkg::WORD_W-1:0]   word_i [RECORD_WORDS],
  output frlwl_pkg::lane_ctl_t           lane_ctl_o,
  output logic [SIDX_W-1:0]              addr_prev_o,
  output logic [SIDX_W-1:0]              addr_cur_o,
  output logic [SIDX_W-1:0]              wr_addr_o,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [frlwl_pkg::WORD_W-1:0]   out_word_o [frlwl_pkg::MAX_WORDS],
  output logic [frlwl_pkg::STATUS_W-1:0] out_status,
  output logic [frlwl_pkg::SLOT_W-1:0]   out_slot
);
  import frlwl_pkg::*;

  fsm_t              state_r, state_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic              part_r, part_nxt;
  logic              cmd_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r [MAX_WORDS];
  logic [WORD_W-1:0] rec_c [MAX_WORDS];
  status_t           status_r, status_c;
  logic [SLOT_W-1:0] slot_r;
  logic [FW-1:0]     fill_m1;
  logic [FW-1:0]     fnx_m1;
  logic [31:0]       fnx_ext;
  logic              accept;
  logic              commit;
  logic              full, erase_due, non_empty;
  logic              all_eq, all_sub, nw0_live, differs;
  logic              wr_en_c;
  wr_mode_t          wr_mode_c;
  out_sel_t          out_sel_c;
  logic [SIDX_W-1:0] wr_addr_c;

  assign accept  = in_valid && in_ready;
  assign commit  = (state_r == S_DEC) && (!out_valid_r || out_ready);
  assign fill_m1 = fill_r - 1'b1;

  assign full      = (fill_r == FW'(RECORD_SLOTS));
  assign erase_due = (fill_r >= FW'(RECORD_SLOTS - 1));
  assign non_empty = (fill_r != '0);

  // Merge the lane findings
  always_comb begin
    all_eq  = 1'b1;
    all_sub = 1'b1;
    for (int i = 0; i < RECORD_WORDS; i++) begin
      all_eq  = all_eq  & flag_i[i].eq;
      all_sub = all_sub & flag_i[i].sub;
    end
  end
  assign nw0_live = !flag_i[0].erased;
  assign differs  = full || !all_eq;

  // Decide the outcome of the item
  always_comb begin
    status_c  = ST_READ;
    out_sel_c = OUT_PREV;
    wr_en_c   = 1'b0;
    wr_mode_c = WR_PLAIN;
    wr_addr_c = fill_r[SIDX_W-1:0];
    fill_nxt  = fill_r;
    part_nxt  = part_r;
    if (cmd_r) begin
      priority if (!differs) begin
        status_c = ST_UNCHANGED;
      end else if (erase_due) begin
        status_c  = ST_ERASE;
        wr_en_c   = 1'b1;
        wr_addr_c = '0;
        out_sel_c = nw0_live ? OUT_NEW : OUT_ERASED;
        fill_nxt  = nw0_live ? FW'(1) : '0;
        part_nxt  = !nw0_live;
      end else if (non_empty && all_sub) begin
        status_c  = ST_OVERWRITE;
        wr_en_c   = 1'b1;
        wr_addr_c = fill_m1[SIDX_W-1:0];
        out_sel_c = OUT_NEW;
      end else begin
        status_c  = ST_APPEND;
        wr_en_c   = 1'b1;
        wr_mode_c = WR_MERGE;
        if (nw0_live) begin
          out_sel_c = OUT_MERGE;
          fill_nxt  = fill_r + 1'b1;
          part_nxt  = 1'b0;
        end else begin
          out_sel_c = OUT_PREV;
          part_nxt  = 1'b1;
        end
      end
    end
  end

  assign fnx_m1  = fill_nxt - 1'b1;
  assign fnx_ext = (fill_nxt == '0) ? 32'd0 : 32'(fnx_m1);

  generate
    for (genvar g = 0; g < MAX_WORDS; g++) begin : g_rec
      if (g < RECORD_WORDS) begin : g_live
        assign rec_c[g] = word_i[g];
      end else begin : g_zero
        assign rec_c[g] = '0;
      end
    end
  endgenerate

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_DEC;
      S_DEC:   if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs towards lanes and channels; take nothing while in reset
  always_comb begin
    in_ready           = (state_r == S_IDLE) && rst_n;
    lane_ctl_o.cap_en  = accept;
    lane_ctl_o.rd_en   = accept;
    lane_ctl_o.wr_en   = wr_en_c && commit;
    lane_ctl_o.wr_mode = wr_mode_c;
    lane_ctl_o.out_sel = out_sel_c;
    lane_ctl_o.prev_ok = non_empty;
    lane_ctl_o.cur_ok  = part_r;
    addr_prev_o        = fill_m1[SIDX_W-1:0];
    addr_cur_o         = fill_r[SIDX_W-1:0];
    wr_addr_o          = wr_addr_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      part_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        fill_r      <= fill_nxt;
        part_r      <= part_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
    end
    if (commit) begin
      status_r   <= status_c;
      slot_r     <= fnx_ext[SLOT_W-1:0];
      out_word_r <= rec_c;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_slot   = slot_r;
  assign out_word_o = out_word_r;

  `FRLWL_ASSERT_NOW(a_fill_below_last, 1'b1, fill_r <= FW'(RECORD_SLOTS - 1), "fill pointer ran past the erase point")
  `FRLWL_ASSERT_NEXT(a_fill_step, commit && status_c != ST_ERASE, fill_r == $past(fill_r) || fill_r == $past(fill_r) + 1'b1, "fill pointer jumped without an erase")
  `FRLWL_ASSERT_NOW(a_result_from_dec, $rose(out_valid_r), $past(state_r == S_DEC), "result appeared without a decision")

endmodule

[design/flash_record_log_wear_level_core.sv]
// Top level of the flash record log core: word lanes plus sequencer.
// Depends on frlwl_pkg, frlwl_in_if, frlwl_out_if, frlwl_lane and frlwl_ctrl.
//
// Usage:
//   in_ch carries one request item: cmd (0 read, 1 update) and a four-word
//   record. out_ch returns exactly one result item per request: the current
//   record after the request, a status code and the slot that holds it.
//   Each request is accepted in one step that reads slots fill-1 and
//   fill from every word bank, then decided in a second step that programs
//   a bank slot and loads the result register. That loop through the bank
//   read port means a new request is accepted only once the last is decided.
//   The fill pointer replaces the scan for the first empty slot, so the cost
//   does not grow with the number of slots.
//   Reset marks the whole page erased through the fill pointer at once; no
//   clearing pass runs and the first item is taken in the cycle after reset.
//   A stalled result stays in the output register; the next item is still
//   accepted and waits in the decide step until the register frees.
module flash_record_log_wear_level_core #(
  parameter int unsigned RECORD_SLOTS = frlwl_pkg::RECORD_SLOTS_DEF,
  parameter int unsigned RECORD_WORDS = frlwl_pkg::RECORD_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  frlwl_in_if.sink           in_ch,
  frlwl_out_if.source        out_ch
);
  import frlwl_pkg::*;

  localparam int unsigned SIDX_W = $clog2(RECORD_SLOTS);

  logic [WORD_W-1:0] nw      [MAX_WORDS];
  logic [WORD_W-1:0] word    [RECORD_WORDS];
  lane_flag_t        flag    [RECORD_WORDS];
  logic [WORD_W-1:0] out_word [MAX_WORDS];
  lane_ctl_t         lane_ctl;
  logic [SIDX_W-1:0] addr_prev;
  logic [SIDX_W-1:0] addr_cur;
  logic [SIDX_W-1:0] wr_addr;

  // Gather the request words so each lane picks its own
  assign nw[0] = in_ch.new_word0;
  assign nw[1] = in_ch.new_word1;
  assign nw[2] = in_ch.new_word2;
  assign nw[3] = in_ch.new_word3;

  // One lane per record word; words beyond the record size are ignored
  generate
    for (genvar g = 0; g < RECORD_WORDS; g++) begin : g_lane
      frlwl_lane #(
        .RECORD_SLOTS (RECORD_SLOTS)
      ) u_lane (
        .clk         (clk),
        .ctl_i       (lane_ctl),
        .addr_prev_i (addr_prev),
        .addr_cur_i  (addr_cur),
        .wr_addr_i   (wr_addr),
        .nw_i        (nw[g]),
        .flag_o      (flag[g]),
        .word_o      (word[g])
      );
    end
  endgenerate

  // Sequence the item and merge what the lanes found
  frlwl_ctrl #(
    .RECORD_SLOTS (RECORD_SLOTS),
    .RECORD_WORDS (RECORD_WORDS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_cmd      (in_ch.cmd),
    .flag_i      (flag),
    .word_i      (word),
    .lane_ctl_o  (lane_ctl),
    .addr_prev_o (addr_prev),
    .addr_cur_o  (addr_cur),
    .wr_addr_o   (wr_addr),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_word_o  (out_word),
    .out_status  (out_ch.status),
    .out_slot    (out_ch.slot_used)
  );

  // Fan the result words out to the channel; unused words read zero
  assign out_ch.cur_word0 = out_word[0];
  assign out_ch.cur_word1 = out_word[1];
  assign out_ch.cur_word2 = out_word[2];
  assign out_ch.cur_word3 = out_word[3];

endmodule

[tb/sv/tb_flash_record_log_wear_level_core.sv]
// Self-checking bench for the flash record log core: random requests with
// random handshake gaps, each result checked against a page image kept here.
// Depends on frlwl_pkg, frlwl_in_if, frlwl_out_if and the core itself.
module tb_flash_record_log_wear_level_core;
  import frlwl_pkg::*;

  localparam int unsigned SLOTS       = RECORD_SLOTS_DEF;
  localparam int unsigned WORDS       = RECORD_WORDS_DEF;
  localparam int unsigned RANDOM_REQS = 750;
  localparam int unsigned IDLE_LIMIT  = 2000;  // cycles with no item on either side
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned REPORT_MAX  = 10;

  localparam logic CMD_READ   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // How a queued request gets its record words. Some are only settled when the
  // request is about to go out, because they depend on the page at that time.
  typedef enum logic [2:0] {
    REQ_RAW,    // words fixed when queued
    REQ_SAME,   // repeat the current record
    REQ_TRIM,   // clear a few bits of the current record
    REQ_FRESH,  // random words
    REQ_HOLE,   // first word all ones, rest random
    REQ_BLANK   // all-ones record
  } req_kind_t;

  typedef logic [MAX_WORDS-1:0][WORD_W-1:0] record_t;

  typedef struct packed {
    req_kind_t kind;
    logic      cmd;
    record_t   words;
  } log_req_t;

  typedef struct packed {
    record_t             words;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } log_view_t;

  logic clk;
  logic rst_n;

  frlwl_in_if  in_ch ();
  frlwl_out_if out_ch ();

  flash_record_log_wear_level_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Page image and the traffic bookkeeping
  logic [WORD_W-1:0] flash_img [SLOTS*WORDS];
  log_req_t          pending_reqs [$];
  log_view_t         expected_views [$];
  int unsigned       req_total;
  int unsigned       n_sent;
  int unsigned       n_acc;
  int unsigned       n_faults;
  int unsigned       idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Page model
  // ---------------------------------------------------------------------------

  // Walk the log: return the first blank slot (SLOTS if none) and hand back
  // the last record in front of it, or all ones on an empty page.
  function automatic int unsigned find_fill(output record_t last);
    last = {MAX_WORDS{ERASED_WORD}};
    for (int unsigned pos = 0; pos < SLOTS; pos++) begin
      if (flash_img[pos*WORDS] == ERASED_WORD) return pos;
      for (int unsigned w = 0; w < WORDS; w++) last[w] = flash_img[pos*WORDS + w];
    end
    return SLOTS;
  endfunction

  function automatic void wipe_image();
    for (int unsigned i = 0; i < SLOTS*WORDS; i++) flash_img[i] = ERASED_WORD;
  endfunction

  // Apply one request to the page image and give the view the core must report.
  function automatic log_view_t apply_request(log_req_t req);
    record_t     cur;
    log_view_t   view;
    int unsigned fill;
    int unsigned pos;
    logic        differs;
    status_t     st;

    st = ST_READ;
    if (req.cmd == CMD_UPDATE) begin
      fill    = find_fill(cur);
      pos     = 0;
      st      = ST_APPEND;
      differs = 1'b1;
      if (fill < SLOTS) begin
        differs = (cur != req.words);
        if (fill > 0) begin
          // in place only when every new word just clears bits of the old one
          if ((~cur & req.words) == '0) begin
            pos = fill - 1;
            st  = ST_OVERWRITE;
          end else begin
            pos = fill;
          end
        end
      end
      if (!differs) begin
        st = ST_UNCHANGED;
      end else begin
        // erase takes priority over an in-place write near the end of the page
        if (fill >= SLOTS - 1) begin
          wipe_image();
          pos = 0;
          st  = ST_ERASE;
        end
        for (int unsigned w = 0; w < WORDS; w++)
          flash_img[pos*WORDS + w] = flash_img[pos*WORDS + w] & req.words[w];
      end
    end
    fill        = find_fill(cur);
    view.words  = cur;
    view.status = st;
    view.slot   = (fill == 0) ? '0 : SLOT_W'(fill - 1);
    return view;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic record_t rand_record();
    record_t r;
    for (int unsigned w = 0; w < MAX_WORDS; w++) r[w] = $urandom;
    return r;
  endfunction

  function automatic void queue_req(req_kind_t kind, logic cmd, record_t words);
    log_req_t r;
    r.kind  = kind;
    r.cmd   = cmd;
    r.words = words;
    if (kind == REQ_HOLE) r.words[0] = ERASED_WORD;
    if (kind == REQ_BLANK) r.words = {MAX_WORDS{ERASED_WORD}};
    pending_reqs.push_back(r);
  endfunction

  // Settle the words of a request against the page as it stands now.
  function automatic log_req_t settle_req(log_req_t r);
    record_t     cur;
    int unsigned fill;
    fill = find_fill(cur);
    // near the end of the page, steer half the fresh writes into trims so that
    // an erase often lands on a write that could have gone in place
    if (r.kind == REQ_FRESH && fill >= SLOTS - 2 && $urandom_range(0, 1) == 1)
      r.kind = REQ_TRIM;
    unique case (r.kind)
      REQ_SAME: r.words = cur;
      REQ_TRIM: begin
        for (int unsigned w = 0; w < MAX_WORDS; w++)
          r.words[w] = cur[w] & ~($urandom & $urandom & $urandom);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: present one item at a time on the falling edge
  // ---------------------------------------------------------------------------
  int unsigned gap_left;
  logic        src_calm;

  always @(negedge clk) begin : req_driver
    log_req_t nxt;
    logic     vld;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left    = 0;
      src_calm    = 1'b0;
    end else begin
      vld = in_ch.valid;
      // drop valid once the item went in at the last rising edge
      if (vld && n_acc == n_sent) vld = 1'b0;
      if (!vld) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          nxt = settle_req(pending_reqs.pop_front());
          in_ch.cmd       <= nxt.cmd;
          in_ch.new_word0 <= nxt.words[0];
          in_ch.new_word1 <= nxt.words[1];
          in_ch.new_word2 <= nxt.words[2];
          in_ch.new_word3 <= nxt.words[3];
          vld = 1'b1;
          n_sent++;
          if ($urandom_range(0, 39) == 0) src_calm = ~src_calm;
          gap_left = (src_calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        end
      end
      in_ch.valid <= vld;
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure, with calm stretches of none
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  logic        sink_calm;

  always @(negedge clk) begin : result_sink
    logic rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   = 0;
      sink_calm    = 1'b0;
    end else begin
      if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (!sink_calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
      if ($urandom_range(0, 63) == 0) sink_calm = ~sink_calm;
      out_ch.ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted request, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : log_monitor
    log_req_t  req;
    log_view_t got;
    log_view_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        req.kind     = REQ_RAW;
        req.cmd      = in_ch.cmd;
        req.words[0] = in_ch.new_word0;
        req.words[1] = in_ch.new_word1;
        req.words[2] = in_ch.new_word2;
        req.words[3] = in_ch.new_word3;
        expected_views.push_back(apply_request(req));
        n_acc++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.words[0] = out_ch.cur_word0;
        got.words[1] = out_ch.cur_word1;
        got.words[2] = out_ch.cur_word2;
        got.words[3] = out_ch.cur_word3;
        got.status   = out_ch.status;
        got.slot     = out_ch.slot_used;
        if (expected_views.size() == 0) begin
          n_faults++;
          if (n_faults <= REPORT_MAX)
            $display("[%0t] result with nothing outstanding: %h st=%0d slot=%0d",
                     $realtime, got.words, got.status, got.slot);
        end else begin
          want = expected_views.pop_front();
          if (got.words[0] !== want.words[0] || got.words[1] !== want.words[1] ||
              got.words[2] !== want.words[2] || got.words[3] !== want.words[3] ||
              got.status !== want.status || got.slot !== want.slot) begin
            n_faults++;
            if (n_faults <= REPORT_MAX)
              $display("[%0t] mismatch: expected %h st=%0d slot=%0d, got %h st=%0d slot=%0d",
                       $realtime, want.words, want.status, want.slot,
                       got.words, got.status, got.slot);
          end
        end
      end
    end
  end

  // Watchdog: give up when neither channel moves an item for too long
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_flash_record_log_wear_level_core: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: queue the requests, reset, wait for the traffic to drain
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    int unsigned r;
    record_t     zero_rec;
    record_t     top_bit_clear;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_READ;
    in_ch.new_word0 = '0;
    in_ch.new_word1 = '0;
    in_ch.new_word2 = '0;
    in_ch.new_word3 = '0;
    out_ch.ready    = 1'b0;
    n_sent          = 0;
    n_acc           = 0;
    n_faults        = 0;
    idle_cycles     = 0;
    wipe_image();

    zero_rec      = '0;
    top_bit_clear = {MAX_WORDS{32'h7FFF_FFFF}};

    // Directed opening: empty page, blank and holed records, every status but erase
    queue_req(REQ_FRESH, CMD_READ, rand_record());     // read of an empty page
    queue_req(REQ_BLANK, CMD_UPDATE, '0);              // all ones on empty: unchanged
    queue_req(REQ_HOLE, CMD_UPDATE, zero_rec);         // written, slot still blank
    queue_req(REQ_FRESH, CMD_READ, rand_record());
    queue_req(REQ_FRESH, CMD_UPDATE, rand_record());   // lands on top of the hole
    queue_req(REQ_SAME, CMD_UPDATE, '0);               // unchanged
    queue_req(REQ_TRIM, CMD_UPDATE, '0);               // in place
    queue_req(REQ_RAW, CMD_UPDATE, zero_rec);          // all zeros, in place
    queue_req(REQ_RAW, CMD_UPDATE, zero_rec);          // all zeros again, unchanged
    queue_req(REQ_RAW, CMD_UPDATE, {{3{ERASED_WORD}}, 32'hFFFF_FFFE});  // append
    queue_req(REQ_RAW, CMD_READ, {MAX_WORDS{ERASED_WORD}});
    queue_req(REQ_BLANK, CMD_UPDATE, '0);              // appended, changes nothing
    queue_req(REQ_RAW, CMD_UPDATE, top_bit_clear);
    queue_req(REQ_TRIM, CMD_UPDATE, '0);
    queue_req(REQ_HOLE, CMD_UPDATE, rand_record());
    queue_req(REQ_FRESH, CMD_UPDATE, rand_record());
    queue_req(REQ_RAW, CMD_UPDATE, {32'h0000_0001, 32'h8000_0000, 32'h0000_0000,
                                    32'h0000_0001});
    queue_req(REQ_SAME, CMD_UPDATE, '0);
    queue_req(REQ_FRESH, CMD_READ, rand_record());

    // Random body: mostly appends so the page fills and erases more than once
    for (int unsigned i = 0; i < RANDOM_REQS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10)      queue_req(REQ_FRESH, CMD_READ, rand_record());
      else if (r < 18) queue_req(REQ_SAME, CMD_UPDATE, '0);
      else if (r < 30) queue_req(REQ_TRIM, CMD_UPDATE, '0);
      else if (r < 33) queue_req(REQ_HOLE, CMD_UPDATE, rand_record());
      else if (r < 35) queue_req(REQ_BLANK, CMD_UPDATE, '0);
      else             queue_req(REQ_FRESH, CMD_UPDATE, rand_record());
    end
    req_total = pending_reqs.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Hold until every request went in and every result came back
    while (n_acc < req_total || expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (n_faults == 0 && expected_views.size() == 0) begin
      $display("tb_flash_record_log_wear_level_core: PASS");
    end else begin
      $display("tb_flash_record_log_wear_level_core: FAIL");
    end
    $finish;
  end

endmodule
